/* hw/rtl/fca_pkg.sv */
package fca_pkg;

	localparam int ADDR_MAX_W = 16;
	localparam int LINK_W     = 16;
	localparam int IDX_W      = 10;

	localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
	localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;
	localparam logic [LINK_W-1:0] RESERVED_BLOCKS = 16'd5;
	localparam logic [IDX_W-1:0]  SEARCH_START_RST = 10'd5;

	localparam logic [2:0] KIND_ALLOC  = 3'd0;
	localparam logic [2:0] KIND_APPEND = 3'd1;
	localparam logic [2:0] KIND_FREE   = 3'd2;
	localparam logic [2:0] KIND_READ   = 3'd3;
	localparam logic [2:0] KIND_FORMAT = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_BADIDX = 2'd2;
	localparam logic [1:0] ST_LOOP   = 2'd3;

	typedef struct packed {
		logic [2:0]       kind;
		logic [IDX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [LINK_W-1:0] block;
	} rsp_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_MAX_W-1:0] rd_addr;
		logic                  wr_en;
		logic [ADDR_MAX_W-1:0] wr_addr;
		logic [LINK_W-1:0]     wr_data;
	} mem_cmd_t;

	typedef struct packed {
		logic fin;
		rsp_t rsp;
	} fin_t;

endpackage

/* hw/rtl/fca_mem.sv */
module fca_mem #(
	parameter int NUM_BLOCKS = 1024
) (
	input  logic                            clk,
	input  fca_pkg::mem_cmd_t               cmd,
	output logic [fca_pkg::LINK_W-1:0]      rdata
);

	localparam int IW = $clog2(NUM_BLOCKS);

	logic [fca_pkg::LINK_W-1:0] mem [NUM_BLOCKS];
	logic [fca_pkg::LINK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr[IW-1:0]] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[cmd.rd_addr[IW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/fca_ctrl.sv */
module fca_ctrl #(
	parameter int NUM_BLOCKS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  fca_pkg::req_t                    request,
	input  logic [fca_pkg::IDX_W-1:0]        search_start,
	input  logic [fca_pkg::LINK_W-1:0]       rdata,
	output fca_pkg::mem_cmd_t                cmd,
	output logic                             busy,
	output fca_pkg::fin_t                    fin
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int SW = $clog2(NUM_BLOCKS + 1);
	localparam logic [16:0]   NB17 = 17'(NUM_BLOCKS);
	localparam logic [IW-1:0] LAST = IW'(NUM_BLOCKS - 1);
	localparam logic [SW-1:0] STEP_MAX = SW'(NUM_BLOCKS);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CLEAR  = 8'b0000_0010,
		S_WALK   = 8'b0000_0100,
		S_SEARCH = 8'b0000_1000,
		S_LINK   = 8'b0001_0000,
		S_FREE   = 8'b0010_0000,
		S_READ   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t                     state_q, state_d;
	logic [2:0]                 kind_q, kind_d;
	logic [IW-1:0]              head_q, head_d;
	logic [IW-1:0]              tail_q, tail_d;
	logic [IW-1:0]              clr_q, clr_d;
	logic [SW-1:0]              steps_q, steps_d;
	logic                       fmt_q, fmt_d;
	logic [1:0]                 status_q, status_d;
	logic [fca_pkg::LINK_W-1:0] blk_q, blk_d;
	logic [IW-1:0]              addr_s1;

	logic [15:0]                ss_eff;
	logic                       ss_ok;
	logic                       idx_ok;
	logic                       link_bad;

	assign ss_eff   = (search_start == '0) ? 16'd1 : 16'(search_start);
	assign ss_ok    = {1'b0, ss_eff} < NB17;
	assign idx_ok   = 17'(request.block_index) < NB17;
	assign link_bad = {1'b0, rdata} >= NB17;
	assign busy     = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		head_d   = head_q;
		tail_d   = tail_q;
		clr_d    = clr_q;
		steps_d  = steps_q;
		fmt_d    = fmt_q;
		status_d = status_q;
		blk_d    = blk_q;
		cmd      = '0;
		fin      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_d   = request.kind;
					head_d   = IW'(request.block_index);
					steps_d  = '0;
					status_d = fca_pkg::ST_OK;
					blk_d    = fca_pkg::LINK_FREE;
					unique case (request.kind) inside
						fca_pkg::KIND_ALLOC: begin
							if (ss_ok) begin
								cmd.rd_en   = 1'b1;
								cmd.rd_addr = ss_eff;
								state_d     = S_SEARCH;
							end else begin
								status_d = fca_pkg::ST_NOFREE;
								state_d  = S_DONE;
							end
						end
						fca_pkg::KIND_APPEND, fca_pkg::KIND_FREE,
						fca_pkg::KIND_READ: begin
							if (idx_ok) begin
								cmd.rd_en   = 1'b1;
								cmd.rd_addr = 16'(request.block_index);
								state_d     = (request.kind == fca_pkg::KIND_READ) ?
									S_READ : S_WALK;
							end else begin
								status_d = fca_pkg::ST_BADIDX;
								state_d  = S_DONE;
							end
						end
						fca_pkg::KIND_FORMAT: begin
							clr_d   = '0;
							fmt_d   = 1'b1;
							state_d = S_CLEAR;
						end
						default: begin
							status_d = fca_pkg::ST_BADIDX;
							state_d  = S_DONE;
						end
					endcase
				end
			end
			S_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = 16'(clr_q);
				cmd.wr_data = (16'(clr_q) < fca_pkg::RESERVED_BLOCKS) ?
					fca_pkg::LINK_END : fca_pkg::LINK_FREE;
				if (clr_q == LAST) begin
					state_d = fmt_q ? S_DONE : S_IDLE;
				end else begin
					clr_d = clr_q + IW'(1);
				end
			end
			S_WALK: begin
				if (rdata == fca_pkg::LINK_FREE) begin
					status_d = fca_pkg::ST_BADIDX;
					state_d  = S_DONE;
				end else if (steps_q >= STEP_MAX) begin
					status_d = fca_pkg::ST_LOOP;
					state_d  = S_DONE;
				end else if (rdata == fca_pkg::LINK_END) begin
					tail_d = addr_s1;
					if (kind_q == fca_pkg::KIND_FREE) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = 16'(head_q);
						state_d     = S_FREE;
					end else if (ss_ok) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = ss_eff;
						state_d     = S_SEARCH;
					end else begin
						status_d = fca_pkg::ST_NOFREE;
						state_d  = S_DONE;
					end
				end else if (link_bad) begin
					status_d = fca_pkg::ST_BADIDX;
					state_d  = S_DONE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = rdata;
					steps_d     = steps_q + SW'(1);
				end
			end
			S_SEARCH: begin
				if (rdata == fca_pkg::LINK_FREE) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = 16'(addr_s1);
					cmd.wr_data = fca_pkg::LINK_END;
					blk_d       = 16'(addr_s1);
					state_d     = (kind_q == fca_pkg::KIND_APPEND) ? S_LINK : S_DONE;
				end else if (addr_s1 == LAST) begin
					status_d = fca_pkg::ST_NOFREE;
					state_d  = S_DONE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = 16'(addr_s1 + IW'(1));
				end
			end
			S_LINK: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = 16'(tail_q);
				cmd.wr_data = blk_q;
				state_d     = S_DONE;
			end
			S_FREE: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = 16'(addr_s1);
				cmd.wr_data = fca_pkg::LINK_FREE;
				if (rdata == fca_pkg::LINK_END) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = rdata;
				end
			end
			S_READ: begin
				if (rdata == fca_pkg::LINK_FREE) begin
					status_d = fca_pkg::ST_BADIDX;
				end else begin
					blk_d = rdata;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				fin.fin        = 1'b1;
				fin.rsp.status = status_q;
				fin.rsp.block  = (status_q == fca_pkg::ST_OK) ? blk_q : fca_pkg::LINK_FREE;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			fmt_q   <= 1'b0;
			kind_q  <= fca_pkg::KIND_ALLOC;
			steps_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			fmt_q   <= fmt_d;
			kind_q  <= kind_d;
			steps_q <= steps_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q   <= head_d;
		tail_q   <= tail_d;
		status_q <= status_d;
		blk_q    <= blk_d;
		if (cmd.rd_en) begin
			addr_s1 <= cmd.rd_addr[IW-1:0];
		end
	end

endmodule

/* hw/rtl/fat_chain_allocator.sv */
// Channel   Signals                     Transfer
// request   start, busy, request        start high while busy low
// config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
// result    done, result                done high for one cycle
//
// After reset a clearing pass rewrites the link table with busy high.
// The table is a single memory with a registered read port; walks and the free search
// read one entry per cycle. Append walks the chain, scans for a free block, then links
// it to the tail. Free walks the chain, then clears it entry by entry. Format rewrites
// the table as after reset. Result shows in the first cycle with busy low.
// The result cannot be stalled; the next request may start while it is shown.
module fat_chain_allocator #(
	parameter int NUM_BLOCKS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  fca_pkg::req_t                request,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fca_pkg::IDX_W-1:0]    cfg_data,
	output logic                         done,
	output fca_pkg::rsp_t                result
);

	logic [fca_pkg::IDX_W-1:0]  search_start_q;
	logic [fca_pkg::LINK_W-1:0] rdata;
	fca_pkg::mem_cmd_t          cmd;
	fca_pkg::fin_t              fin;
	logic                       done_q;
	fca_pkg::rsp_t              result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_start_q <= fca_pkg::SEARCH_START_RST;
			done_q         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				search_start_q <= cfg_data;
			end
			done_q <= fin.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.fin) begin
			result_q <= fin.rsp;
		end
	end

	fca_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.search_start (search_start_q),
		.rdata        (rdata),
		.cmd          (cmd),
		.busy         (busy),
		.fin          (fin)
	);

	fca_mem #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_mem (
		.clk   (clk),
		.cmd   (cmd),
		.rdata (rdata)
	);

	assign done   = done_q;
	assign result = result_q;

endmodule

/* hw/rtl/fca_checker.sv */
module fca_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input fca_pkg::rsp_t              result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is in progress");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in progress");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != fca_pkg::ST_OK) |-> (result.block == fca_pkg::LINK_FREE))
		else $error("failed request returned a nonzero block");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);

/* test/tb_fat_chain_allocator.sv */
module tb_fat_chain_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLK = 1024;
	localparam int IW   = fca_pkg::IDX_W;
	localparam int LW   = fca_pkg::LINK_W;

	typedef struct {
		fca_pkg::req_t req;
		fca_pkg::rsp_t rsp;
	} outcome_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	fca_pkg::req_t     request   = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IW-1:0]     cfg_data  = '0;
	logic              done;
	fca_pkg::rsp_t     result;

	logic [LW-1:0]     fat_links [NBLK];
	logic [IW-1:0]     window_start;
	outcome_t          outcomes_due [$];
	outcome_t          oldest_due;
	fca_pkg::rsp_t     last_predicted;
	int                chain_heads [$];
	int                sender_idle_pct;
	int                mismatch_count = 0;

	fat_chain_allocator #(.NUM_BLOCKS(NBLK)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	always #6 clk = ~clk;

	function automatic void fat_format();
		for (int i = 0; i < NBLK; i++)
			fat_links[i] = (i < fca_pkg::RESERVED_BLOCKS) ? fca_pkg::LINK_END :
				fca_pkg::LINK_FREE;
	endfunction

	function automatic bit fat_in_use(input int idx);
		return idx < NBLK && fat_links[idx] != fca_pkg::LINK_FREE;
	endfunction

	function automatic logic [1:0] fat_walk(input int head, output int tail);
		int hops;
		tail = head;
		hops = 0;
		if (!fat_in_use(head))
			return fca_pkg::ST_BADIDX;
		while (fat_links[tail] != fca_pkg::LINK_END) begin
			if (!fat_in_use(int'(fat_links[tail])))
				return fca_pkg::ST_BADIDX;
			hops++;
			if (hops >= NBLK)
				return fca_pkg::ST_LOOP;
			tail = int'(fat_links[tail]);
		end
		return fca_pkg::ST_OK;
	endfunction

	function automatic int fat_find_free();
		for (int i = (window_start == 0) ? 1 : int'(window_start); i < NBLK; i++)
			if (fat_links[i] == fca_pkg::LINK_FREE)
				return i;
		return 0;
	endfunction

	function automatic fca_pkg::rsp_t fat_apply(input fca_pkg::req_t r);
		fca_pkg::rsp_t rsp;
		int tail;
		int nb;
		int cur;
		int nxt;
		rsp.status = fca_pkg::ST_OK;
		rsp.block = '0;
		case (r.kind)
			fca_pkg::KIND_ALLOC: begin
				nb = fat_find_free();
				if (nb == 0) begin
					rsp.status = fca_pkg::ST_NOFREE;
				end else begin
					fat_links[nb] = fca_pkg::LINK_END;
					rsp.block = LW'(nb);
				end
			end
			fca_pkg::KIND_APPEND: begin
				rsp.status = fat_walk(int'(r.block_index), tail);
				if (rsp.status == fca_pkg::ST_OK) begin
					nb = fat_find_free();
					if (nb == 0) begin
						rsp.status = fca_pkg::ST_NOFREE;
					end else begin
						fat_links[nb] = fca_pkg::LINK_END;
						fat_links[tail] = LW'(nb);
						rsp.block = LW'(nb);
					end
				end
			end
			fca_pkg::KIND_FREE: begin
				rsp.status = fat_walk(int'(r.block_index), tail);
				if (rsp.status == fca_pkg::ST_OK) begin
					cur = int'(r.block_index);
					do begin
						nxt = int'(fat_links[cur]);
						fat_links[cur] = fca_pkg::LINK_FREE;
						cur = nxt;
					end while (nxt != int'(fca_pkg::LINK_END) && nxt < NBLK);
				end
			end
			fca_pkg::KIND_READ: begin
				if (fat_in_use(int'(r.block_index)))
					rsp.block = fat_links[r.block_index];
				else
					rsp.status = fca_pkg::ST_BADIDX;
			end
			fca_pkg::KIND_FORMAT: begin
				fat_format();
			end
			default: begin
				rsp.status = fca_pkg::ST_BADIDX;
			end
		endcase
		if (rsp.status != fca_pkg::ST_OK)
			rsp.block = '0;
		return rsp;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (outcomes_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: status %0d block %0d",
					result.status, result.block));
			end else begin
				oldest_due = outcomes_due.pop_front();
				if (result.status !== oldest_due.rsp.status)
					report_mismatch($sformatf("kind %0d index %0d: status %0d, want %0d",
						oldest_due.req.kind, oldest_due.req.block_index,
						result.status, oldest_due.rsp.status));
				if (result.block !== oldest_due.rsp.block)
					report_mismatch($sformatf("kind %0d index %0d: block %0d, want %0d",
						oldest_due.req.kind, oldest_due.req.block_index,
						result.block, oldest_due.rsp.block));
			end
		end
	end

	task automatic send_request(input fca_pkg::req_t r);
		int gap;
		outcome_t entry;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		last_predicted = fat_apply(r);
		entry.req = r;
		entry.rsp = last_predicted;
		outcomes_due.push_back(entry);
	endtask

	task automatic issue(input logic [2:0] kind, input int idx);
		fca_pkg::req_t r;
		r.kind = kind;
		r.block_index = IW'(idx);
		send_request(r);
	endtask

	task automatic drain_outcomes();
		start <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_search_start(input logic [IW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		window_start = value;
	endtask

	task automatic test_reads();
		issue(fca_pkg::KIND_READ, 0);
		issue(fca_pkg::KIND_READ, NBLK - 1);
	endtask

	task automatic test_chains();
		issue(fca_pkg::KIND_ALLOC, 0);
		issue(fca_pkg::KIND_APPEND, 5);
		issue(fca_pkg::KIND_APPEND, 5);
		issue(fca_pkg::KIND_READ, 5);
		// cut the chain in the middle, leaving a dangling link behind
		issue(fca_pkg::KIND_FREE, 6);
		issue(fca_pkg::KIND_APPEND, 5);
		issue(fca_pkg::KIND_FREE, 5);
		issue(fca_pkg::KIND_ALLOC, 0);
		issue(fca_pkg::KIND_FREE, 5);
		issue(fca_pkg::KIND_APPEND, 0);
		issue(fca_pkg::KIND_FREE, 0);
		issue(fca_pkg::KIND_READ, 0);
	endtask

	task automatic test_unused_kinds();
		issue(3'd5, NBLK - 1);
		issue(3'd6, 0);
		issue(3'd7, 5);
	endtask

	task automatic test_format();
		issue(fca_pkg::KIND_FORMAT, 0);
		issue(fca_pkg::KIND_READ, 0);
	endtask

	task automatic test_search_window();
		drain_outcomes();
		write_search_start(10'd1022);
		issue(fca_pkg::KIND_ALLOC, 0);
		issue(fca_pkg::KIND_ALLOC, 0);
		issue(fca_pkg::KIND_ALLOC, 0);
		issue(fca_pkg::KIND_APPEND, 1022);
		drain_outcomes();
		write_search_start(10'd0);
		issue(fca_pkg::KIND_FREE, 0);
		issue(fca_pkg::KIND_FREE, 1);
		issue(fca_pkg::KIND_ALLOC, 0);
	endtask

	task automatic test_random_traffic(input logic [IW-1:0] window, input int idle_pct,
		input int count);
		fca_pkg::req_t r;
		int pick;
		int slot;
		int h;
		drain_outcomes();
		write_search_start(window);
		sender_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (chain_heads.size() > 20)
				pick = 60;
			slot = (chain_heads.size() == 0) ? -1 : $urandom_range(chain_heads.size() - 1);
			h = (slot < 0) ? $urandom_range(NBLK - 1) : chain_heads[slot];
			r.block_index = IW'(h);
			if (pick < 25) begin
				r.kind = fca_pkg::KIND_ALLOC;
			end else if (pick < 55) begin
				r.kind = fca_pkg::KIND_APPEND;
			end else if (pick < 72) begin
				r.kind = fca_pkg::KIND_FREE;
				if ($urandom_range(3) == 0 && fat_links[h] != fca_pkg::LINK_FREE &&
					fat_links[h] < NBLK)
					r.block_index = IW'(fat_links[h]);
				else if (slot >= 0)
					chain_heads.delete(slot);
			end else if (pick < 87) begin
				r.kind = fca_pkg::KIND_READ;
				if ($urandom_range(1) == 1)
					r.block_index = IW'($urandom_range(NBLK - 1));
			end else if (pick < 88) begin
				r.kind = fca_pkg::KIND_FORMAT;
			end else begin
				r.kind = 3'($urandom_range(7));
				r.block_index = IW'($urandom_range(NBLK - 1));
			end
			send_request(r);
			if (r.kind == fca_pkg::KIND_ALLOC && last_predicted.status == fca_pkg::ST_OK)
				chain_heads.push_back(int'(last_predicted.block));
			if (r.kind == fca_pkg::KIND_FORMAT)
				chain_heads.delete();
			if ($urandom_range(99) == 0)
				drain_outcomes();
		end
	endtask

	initial begin
		#250_000_000;
		$display("fat_chain_allocator test failed");
		$finish;
	end

	initial begin
		fat_format();
		window_start = fca_pkg::SEARCH_START_RST;
		sender_idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_reads();
		test_chains();
		test_unused_kinds();
		test_format();
		test_search_window();
		test_random_traffic(10'd5, 0, 500);
		test_random_traffic(10'd1023, 77, 120);
		test_random_traffic(10'd0, 16, 400);
		test_random_traffic(IW'($urandom_range(1023, 1)), 77, 350);
		test_random_traffic(10'd1, 0, 380);
		drain_outcomes();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && outcomes_due.size() == 0) begin
			$display("fat_chain_allocator test passed");
		end else begin
			$display("fat_chain_allocator test failed");
		end
		$finish;
	end

endmodule
